### design/byte_pattern_match_finder_macros.svh
// Assertion macros shared by the byte pattern match finder RTL.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef BYTE_PATTERN_MATCH_FINDER_MACROS_SVH
`define BYTE_PATTERN_MATCH_FINDER_MACROS_SVH

// The check must hold in the same cycle in which the trigger is seen.
`define BPMF_ASSERT_NOW(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) \
    else $error(msg);

// The check must hold in the cycle after the trigger is seen.
`define BPMF_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error(msg);

`endif

### design/bpmf_pkg.sv
// Package for the byte pattern match finder: field widths, register codes and types.
// Used by the channel interfaces, the cell, the aligner and the top level.
`timescale 1ns / 1ps

package bpmf_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned MAX_PATTERN_DEF   = 64;
  localparam int unsigned POSITION_BITS_DEF = 32;

  // Fixed field widths of the channels and the configuration port.
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LENGTH_W    = 7;
  localparam int unsigned GAP_W       = 16;
  localparam int unsigned START_W     = 32;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_GAP        = 1'b1;

  // Item modes.
  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_TEXT    = 1'b1;

  // Reset value of the pattern length register.
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 7'd1;

  typedef logic [BYTE_W-1:0] byte_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic load;    // write this cell's pattern byte
    logic shift;   // a text item is accepted: shift the window and compare
    logic active;  // this cell lies inside the pattern length in use
  } cell_ctrl_t;

endpackage

### design/bpmf_in_if.sv
// Input channel of the byte pattern match finder: valid/ready and one input item.
// Depends on bpmf_pkg for the field widths.
`timescale 1ns / 1ps

interface bpmf_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [bpmf_pkg::INDEX_W-1:0]    pattern_index;
  bpmf_pkg::byte_t                 data_byte;
  logic                            end_of_text;

  modport source (output valid, mode, pattern_index, data_byte, end_of_text,
                  input ready);
  modport sink (input valid, mode, pattern_index, data_byte, end_of_text,
                output ready);
endinterface

### design/bpmf_out_if.sv
// Result channel of the byte pattern match finder: valid/ready and one result item.
// Depends on bpmf_pkg for the field widths.
`timescale 1ns / 1ps

interface bpmf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         match_found;
  logic [bpmf_pkg::START_W-1:0] match_start;

  modport source (output valid, match_found, match_start, input ready);
  modport sink (input valid, match_found, match_start, output ready);
endinterface

### design/byte_pattern_match_finder.sv
// Byte pattern match finder: cell chain, window aligner and match bookkeeping.
// Depends on bpmf_pkg, bpmf_in_if, bpmf_out_if, bpmf_cell and bpmf_align.
//
// Use: load the pattern with mode 0 items (pattern_index, data_byte), set
// pattern_length and min_gap on the configuration port while the block is
// idle, then stream text bytes with mode 1 items, one per cycle. Each text
// item gives one result item on the result channel: match_found and the
// offset of the first matched byte from the start of the text. A pattern
// load gives no result. end_of_text on a text item restarts the offsets at
// zero after that byte. A text item passes through the compare stage and
// then the result register, from which the receiver takes its result; one
// item is taken every cycle while the receiver keeps up. That rate is set
// by the search start update, which finishes while each item is in the
// compare stage. After reset the length is 1, min_gap is 0, the
// offsets are zero and the pattern bytes are unknown until loaded. When the
// receiver stalls, the result register holds its item, one more item is
// taken into the compare stage, and then ready drops until the result moves.
`timescale 1ns / 1ps
`include "byte_pattern_match_finder_macros.svh"

module byte_pattern_match_finder #(
  parameter int unsigned MAX_PATTERN   = bpmf_pkg::MAX_PATTERN_DEF,
  parameter int unsigned POSITION_BITS = bpmf_pkg::POSITION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bpmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bpmf_pkg::CFG_DATA_W-1:0]   cfg_data,
  bpmf_in_if.sink                           feed,
  bpmf_out_if.source                        result
);

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned SH_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned POS_W = POSITION_BITS;
  localparam int unsigned SS_W  = POSITION_BITS + 1;
  localparam int unsigned SUM_W = ((SS_W > bpmf_pkg::GAP_W) ? SS_W : bpmf_pkg::GAP_W) + 1;
  localparam logic [SS_W-1:0]  SS_MAX  = '1;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Configuration registers.
  logic [bpmf_pkg::LENGTH_W-1:0] pattern_length;
  logic [bpmf_pkg::GAP_W-1:0]    min_gap;

  // Position state, compare stage and result register.
  logic [POS_W-1:0]  byte_position;
  logic [POS_W-1:0]  byte_position_next;
  logic [SS_W-1:0]   search_start;
  logic              s1_valid;
  logic              s1_long;
  logic [POS_W-1:0]  s1_start;
  logic [SS_W-1:0]   s1_end;
  logic              s1_eot;
  logic              out_valid;
  logic              out_found;
  logic [bpmf_pkg::START_W-1:0] out_start;

  logic              accept;
  logic              text_acc;
  logic              load_acc;
  logic              advance;
  logic [LEN_W-1:0]  len_use;
  logic [SH_W-1:0]   align_shift;
  logic [SS_W-1:0]   pos_x;
  logic [SS_W-1:0]   len_x;
  logic [SS_W-1:0]   lm1_x;
  logic [SS_W-1:0]   start_x;
  logic              long_enough;
  logic [SUM_W-1:0]  gap_sum;
  logic [SS_W-1:0]   gap_sat;
  logic [SS_W-1:0]   ss_after;
  logic              eq_all;
  logic              hit;

  bpmf_pkg::byte_t   new_win [MAX_PATTERN];
  bpmf_pkg::byte_t   cur_win [MAX_PATTERN];
  bpmf_pkg::byte_t   aligned [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] eq_vec;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= bpmf_pkg::LENGTH_RESET;
      min_gap        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpmf_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[bpmf_pkg::LENGTH_W-1:0];
        bpmf_pkg::REG_MIN_GAP:        min_gap        <= cfg_data;
      endcase
    end
  end

  // Pattern length in use: zero counts as one, large values clip to the cell count.
  always_comb begin
    if (pattern_length == '0) begin
      len_use = LEN_W'(1);
    end else if (32'(pattern_length) > 32'(MAX_PATTERN)) begin
      len_use = LEN_W'(MAX_PATTERN);
    end else begin
      len_use = LEN_W'(pattern_length);
    end
  end

  // Handshake: the compare stage moves on whenever the result register frees up.
  assign accept     = feed.valid && feed.ready;
  assign text_acc   = accept && (feed.mode == bpmf_pkg::MODE_TEXT);
  assign load_acc   = accept && (feed.mode == bpmf_pkg::MODE_PATTERN);
  assign advance    = !out_valid || result.ready;
  assign feed.ready = !s1_valid || advance;

  // Chain of cells; the window enters at cell 0.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    bpmf_pkg::cell_ctrl_t ctrl;

    if (k == 0) begin : g_head
      assign new_win[k] = feed.data_byte;
    end else begin : g_body
      assign new_win[k] = cur_win[k-1];
    end

    assign ctrl.load   = load_acc && (32'(feed.pattern_index) == 32'(k));
    assign ctrl.shift  = text_acc;
    assign ctrl.active = 32'(k) < 32'(len_use);

    bpmf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .load_byte  (feed.data_byte),
      .shift_in   (new_win[k]),
      .align_byte (aligned[k]),
      .shift_out  (cur_win[k]),
      .eq         (eq_vec[k])
    );
  end

  // Align the window as it will be after this byte with the pattern cells.
  assign align_shift = SH_W'(MAX_PATTERN - 32'(len_use));

  bpmf_align #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_align (
    .window  (new_win),
    .shift   (align_shift),
    .aligned (aligned)
  );

  // Start offset of the window ending at this byte. The end offset
  // start + length cannot pass the search start range, so no clipping.
  assign pos_x       = SS_W'(byte_position);
  assign len_x       = SS_W'(len_use);
  assign lm1_x       = len_x - SS_W'(1);
  assign long_enough = pos_x >= lm1_x;
  assign start_x     = pos_x - lm1_x;

  // Byte position counts text bytes, stops at its maximum and restarts at zero after end of text.
  always_comb begin
    if (feed.end_of_text) begin
      byte_position_next = '0;
    end else if (byte_position != POS_MAX) begin
      byte_position_next = byte_position + POS_W'(1);
    end else begin
      byte_position_next = byte_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (text_acc) begin
      byte_position <= byte_position_next;
    end
  end

  // Compare stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (feed.ready) begin
      s1_valid <= text_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc) begin
      s1_long  <= long_enough;
      s1_start <= start_x[POS_W-1:0];
      s1_end   <= start_x + len_x;
      s1_eot   <= feed.end_of_text;
    end
  end

  // Match decision and the next search start.
  assign eq_all  = &eq_vec;
  assign hit     = s1_valid && s1_long && eq_all && (SS_W'(s1_start) >= search_start);
  assign gap_sum = SUM_W'(search_start) + SUM_W'(min_gap);
  assign gap_sat = (gap_sum > SUM_W'(SS_MAX)) ? SS_MAX : gap_sum[SS_W-1:0];
  assign ss_after = (gap_sat > s1_end) ? gap_sat : s1_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_start <= '0;
    end else if (s1_valid && advance) begin
      if (s1_eot) begin
        search_start <= '0;
      end else if (hit) begin
        search_start <= ss_after;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_found <= hit;
      out_start <= hit ? bpmf_pkg::START_W'(s1_start) : '0;
    end
  end

  assign result.valid       = out_valid;
  assign result.match_found = out_found;
  assign result.match_start = out_start;

  // Checks on the pipeline and the match bookkeeping.
  `BPMF_ASSERT_NOW(a_stall_blocks_input, s1_valid && !advance, !feed.ready, "input taken while the compare stage is stalled")
  `BPMF_ASSERT_NOW(a_no_match_zero_start, out_valid && !out_found, out_start == '0, "match start set without a match")
  `BPMF_ASSERT_NEXT(a_search_passes_match, hit && advance && !s1_eot, search_start > SS_W'($past(s1_start)), "search start did not move past the reported match")
  `BPMF_ASSERT_NEXT(a_eot_restarts_offset, text_acc && feed.end_of_text, byte_position == '0, "byte position not restarted after end of text")

endmodule

### design/bpmf_cell.sv
// One cell of the match chain: a window byte, a pattern byte and a compare flag.
// Depends on bpmf_pkg for the byte and control types.
`timescale 1ns / 1ps

module bpmf_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  bpmf_pkg::cell_ctrl_t ctrl,
  input  bpmf_pkg::byte_t      load_byte,
  input  bpmf_pkg::byte_t      shift_in,
  input  bpmf_pkg::byte_t      align_byte,
  output bpmf_pkg::byte_t      shift_out,
  output logic                 eq
);

  bpmf_pkg::byte_t window_byte;
  bpmf_pkg::byte_t pattern_byte;
  logic            eq_flag;

  // Window byte moves one cell along for every text item.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_byte <= '0;
    end else if (ctrl.shift) begin
      window_byte <= shift_in;
    end
  end

  // Pattern byte is written by a pattern load addressed to this cell.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pattern_byte <= load_byte;
    end
  end

  // Compare the aligned text byte of the new window with this pattern byte.
  // A cell beyond the pattern length always agrees.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      eq_flag <= !ctrl.active || (align_byte == pattern_byte);
    end
  end

  assign shift_out = window_byte;
  assign eq        = eq_flag;

endmodule

### design/bpmf_align.sv
// Aligner: lines up the newest pattern-length window bytes with the pattern cells.
// A logarithmic shift network; depends on bpmf_pkg for the byte type.
`timescale 1ns / 1ps

module bpmf_align #(
  parameter int unsigned MAX_PATTERN = bpmf_pkg::MAX_PATTERN_DEF,
  localparam int unsigned SH_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  bpmf_pkg::byte_t   window [MAX_PATTERN],
  input  logic [SH_W-1:0]   shift,
  output bpmf_pkg::byte_t   aligned [MAX_PATTERN]
);

  // stage[0] holds the window oldest-first; each level shifts by a power of two.
  bpmf_pkg::byte_t stage [SH_W+1][MAX_PATTERN];

  for (genvar m = 0; m < MAX_PATTERN; m++) begin : g_rev
    assign stage[0][m] = window[MAX_PATTERN-1-m];
  end

  for (genvar b = 0; b < SH_W; b++) begin : g_level
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pos
      if (k + (1 << b) < MAX_PATTERN) begin : g_in
        assign stage[b+1][k] = shift[b] ? stage[b][k+(1<<b)] : stage[b][k];
      end else begin : g_edge
        assign stage[b+1][k] = shift[b] ? '0 : stage[b][k];
      end
    end
  end

  // Output k carries the byte that pattern position k must equal.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_out
    assign aligned[k] = stage[SH_W][k];
  end

endmodule

### dv/byte_pattern_match_finder_checker.sv
// Checker for the byte pattern match finder: watches the configuration port and both channels.
// It predicts each result item and compares it; depends on bpmf_pkg, bpmf_in_if and bpmf_out_if.
`timescale 1ns / 1ps

module byte_pattern_match_finder_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bpmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bpmf_pkg::CFG_DATA_W-1:0]   cfg_data,
  bpmf_in_if                                feed,
  bpmf_out_if                               result,
  output int unsigned                       errors,
  output int unsigned                       pending
);
  import bpmf_pkg::*;

  localparam int unsigned PATTERN_SLOTS = MAX_PATTERN_DEF;
  localparam logic [POSITION_BITS_DEF-1:0] POSITION_LIMIT = '1;
  localparam logic [POSITION_BITS_DEF:0]   START_LIMIT    = '1;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] start;
  } match_t;

  // Expected result items, newest first.
  match_t match_queue[$];

  // Predicted state of the block.
  byte_t                      pattern_bytes [PATTERN_SLOTS];
  byte_t                      recent_bytes  [PATTERN_SLOTS];
  logic [LENGTH_W-1:0]        length_reg;
  logic [GAP_W-1:0]           gap_reg;
  logic [POSITION_BITS_DEF-1:0] text_offset;
  logic [POSITION_BITS_DEF:0]   earliest_start;

  // Sum that sticks at the largest search start.
  function automatic logic [POSITION_BITS_DEF:0] capped_sum(
      input logic [POSITION_BITS_DEF:0] a, input logic [POSITION_BITS_DEF:0] b);
    logic [POSITION_BITS_DEF+1:0] total;
    total = (POSITION_BITS_DEF+2)'(a) + (POSITION_BITS_DEF+2)'(b);
    return (total > (POSITION_BITS_DEF+2)'(START_LIMIT)) ? START_LIMIT
                                                          : total[POSITION_BITS_DEF:0];
  endfunction

  // Shift one text byte into the window, decide whether it completes a match,
  // and advance the offset and the search start.
  function automatic match_t scan_text_byte(input byte_t data, input logic last);
    match_t verdict;
    int unsigned span;
    logic [POSITION_BITS_DEF:0] first;
    logic [POSITION_BITS_DEF:0] after_gap;
    logic [POSITION_BITS_DEF:0] after_match;
    verdict.found = 1'b0;
    verdict.start = '0;
    for (int k = PATTERN_SLOTS - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
    recent_bytes[0] = data;
    if (length_reg == 0) span = 1;
    else if (length_reg > PATTERN_SLOTS) span = PATTERN_SLOTS;
    else span = 32'(length_reg);

    if (text_offset >= span - 1) begin
      first = (POSITION_BITS_DEF+1)'(text_offset) - (POSITION_BITS_DEF+1)'(span - 1);
      if (first >= earliest_start) begin
        verdict.found = 1'b1;
        for (int k = 0; k < span; k++) begin
          if (recent_bytes[span - 1 - k] !== pattern_bytes[k]) verdict.found = 1'b0;
        end
      end
      if (verdict.found) begin
        verdict.start = first[START_W-1:0];
        after_gap     = capped_sum(earliest_start, (POSITION_BITS_DEF+1)'(gap_reg));
        after_match   = capped_sum(first, (POSITION_BITS_DEF+1)'(span));
        earliest_start = (after_gap > after_match) ? after_gap : after_match;
      end
    end

    if (text_offset != POSITION_LIMIT) text_offset++;
    // The marked byte is examined first, then the next text starts at zero.
    if (last) begin
      text_offset    = '0;
      earliest_start = '0;
    end
    return verdict;
  endfunction

  always @(posedge clk) begin
    match_t seen;
    match_t want;
    if (rst) begin
      for (int k = 0; k < PATTERN_SLOTS; k++) begin
        pattern_bytes[k] = '0;
        recent_bytes[k]  = '0;
      end
      length_reg     = LENGTH_RESET;
      gap_reg        = '0;
      text_offset    = '0;
      earliest_start = '0;
      match_queue.delete();
    end else begin
      // Compare an accepted result item with the oldest expectation.
      if (result.valid && result.ready) begin
        seen.found = result.match_found;
        seen.start = result.match_start;
        if (match_queue.size() == 0) begin
          errors++;
          $display("%0t: result item with none expected: expected nothing, got found=%0b start=%0d",
                   $time, seen.found, seen.start);
        end else begin
          want = match_queue.pop_back();
          if (seen.found !== want.found) begin
            errors++;
            $display("%0t: match_found mismatch: expected %0b, got %0b",
                     $time, want.found, seen.found);
          end
          if (seen.start !== want.start) begin
            errors++;
            $display("%0t: match_start mismatch: expected %0d, got %0d",
                     $time, want.start, seen.start);
          end
        end
      end

      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: length_reg = cfg_data[LENGTH_W-1:0];
          REG_MIN_GAP:        gap_reg    = cfg_data[GAP_W-1:0];
          default: ;
        endcase
      end

      // Accepted input item: a pattern load or a text byte.
      if (feed.valid && feed.ready) begin
        if (feed.mode == MODE_PATTERN) pattern_bytes[feed.pattern_index] = feed.data_byte;
        else match_queue.push_front(scan_text_byte(feed.data_byte, feed.end_of_text));
      end
    end
    pending <= match_queue.size();
  end

endmodule

### dv/byte_pattern_match_finder_test.sv
// Top of the byte pattern match finder testbench: clock, reset, stimulus and verdict.
// Depends on bpmf_pkg, the channel interfaces, the block and byte_pattern_match_finder_checker.
`timescale 1ns / 1ps

module byte_pattern_match_finder_test;
  import bpmf_pkg::*;

  localparam int unsigned ITEM_TARGET = 850;
  localparam int unsigned SLOTS       = MAX_PATTERN_DEF;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_SLOW} sink_style_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int unsigned            errors;
  int unsigned            pending;

  bpmf_in_if  feed ();
  bpmf_out_if result ();

  // Copy of the loaded pattern, used to build text that matches.
  byte_t       needle [SLOTS];
  int unsigned burst_left;
  int unsigned items_sent;
  sink_style_t sink_style;
  int unsigned sink_left;

  byte_pattern_match_finder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .feed      (feed),
    .result    (result)
  );

  byte_pattern_match_finder_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .feed      (feed),
    .result    (result),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver switches at random between stall styles.
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_style = sink_style_t'($urandom_range(0, 3));
      sink_left  = $urandom_range(10, 60);
    end
    sink_left--;
    case (sink_style)
      SINK_OPEN:     result.ready <= 1'b1;
      SINK_COIN:     result.ready <= ($urandom_range(0, 1) == 1);
      SINK_PERIODIC: result.ready <= (sink_left % 4 != 0);
      default:       result.ready <= (sink_left % 12 == 0);
    endcase
  end

  // Hard limit on the run time.
  initial begin
    #20_000_000;
    $display("byte_pattern_match_finder verification failed");
    $finish;
  end

  function automatic int unsigned span_of(input logic [LENGTH_W-1:0] len);
    if (len == 0) return 1;
    if (len > SLOTS) return SLOTS;
    return 32'(len);
  endfunction

  // Offer one item; the sender runs in bursts with random gaps between them.
  // Called and left at a falling edge.
  task automatic push_item(input logic m, input logic [INDEX_W-1:0] idx,
                           input byte_t data, input logic last);
    int unsigned pause;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      pause = $urandom_range(0, 5);
      if (pause != 0) begin
        feed.valid <= 1'b0;
        repeat (pause) @(negedge clk);
      end
    end
    feed.valid         <= 1'b1;
    feed.mode          <= m;
    feed.pattern_index <= idx;
    feed.data_byte     <= data;
    feed.end_of_text   <= last;
    @(posedge clk);
    while (!feed.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_byte(input logic [INDEX_W-1:0] idx, input byte_t data, input logic last);
    push_item(MODE_PATTERN, idx, data, last);
    needle[idx] = data;
  endtask

  task automatic send_text(input byte_t data, input logic last);
    push_item(MODE_TEXT, INDEX_W'($urandom_range(0, SLOTS - 1)), data, last);
  endtask

  // Hold the sender until every expected result item has come, then let a
  // trailing pattern load finish.
  task automatic settle();
    feed.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input logic [LENGTH_W-1:0] len, input logic [GAP_W-1:0] gap);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_PATTERN_LENGTH;
    cfg_data  <= CFG_DATA_W'(len);
    @(negedge clk);
    cfg_index <= REG_MIN_GAP;
    cfg_data  <= gap;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [LENGTH_W-1:0] len;
    logic [GAP_W-1:0]    gap;
    int unsigned         span;
    int unsigned         letters;
    int unsigned         budget;
    int unsigned         pick;
    int unsigned         flaw;
    byte_t               base;
    byte_t               planned[$];

    clk                = 1'b0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_PATTERN_LENGTH;
    cfg_data           = '0;
    feed.valid         = 1'b0;
    feed.mode          = MODE_PATTERN;
    feed.pattern_index = '0;
    feed.data_byte     = '0;
    feed.end_of_text   = 1'b0;
    result.ready       = 1'b0;
    burst_left         = 0;
    items_sent         = 0;
    sink_left          = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values: one-byte pattern, no gap. An end mark on a load is ignored.
    load_byte(INDEX_W'(0), 8'hFF, 1'b1);
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b1);
    send_text(8'hFF, 1'b0);

    // Fill the whole pattern store so that no unwritten entry is ever compared.
    for (int k = 0; k < SLOTS; k++) load_byte(INDEX_W'(k), byte_t'($urandom_range(0, 255)), 1'b0);

    // A length above the store size saturates to the full pattern, which is then sent as text.
    configure(7'd127, 16'd0);
    for (int k = 0; k < SLOTS; k++) send_text(needle[k], k == SLOTS - 1);

    // Overlapping matches spaced by the larger of the gap and the length.
    load_byte(INDEX_W'(0), 8'h61, 1'b0);
    load_byte(INDEX_W'(1), 8'h61, 1'b0);
    configure(7'd2, 16'd3);
    for (int k = 0; k < 7; k++) send_text(8'h61, k == 6);

    // Largest gap: only the first match of a text counts, until the end mark.
    configure(7'd1, 16'hFFFF);
    send_text(8'h61, 1'b0);
    send_text(8'h61, 1'b0);
    send_text(8'h61, 1'b1);
    send_text(8'h61, 1'b0);

    // Length zero behaves as one.
    configure(7'd0, 16'd0);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b0);
    send_text(8'h61, 1'b1);

    // Random phases: mostly copies of the pattern over a small alphabet.
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) len = 7'd0;
      else if (pick == 1) len = 7'd127;
      else if (pick == 2) len = 7'd64;
      else if (pick == 3) len = LENGTH_W'($urandom_range(7, 127));
      else len = LENGTH_W'($urandom_range(1, 6));
      pick = $urandom_range(0, 9);
      if (pick < 4) gap = 16'd0;
      else if (pick < 7) gap = GAP_W'($urandom_range(1, 8));
      else if (pick < 8) gap = 16'hFFFF;
      else gap = GAP_W'($urandom_range(0, 65535));
      configure(len, gap);

      span    = span_of(len);
      base    = byte_t'($urandom_range(0, 255));
      letters = $urandom_range(1, 3);
      for (int k = 0; k < span; k++)
        load_byte(INDEX_W'(k), byte_t'(base + $urandom_range(0, letters - 1)),
                  1'($urandom_range(0, 1)));

      budget = span * $urandom_range(2, 4) + $urandom_range(8, 30);
      planned.delete();
      for (int n = 0; n < budget; n++) begin
        if (planned.size() == 0) begin
          pick = $urandom_range(0, 9);
          if (pick < 5) begin
            // A copy of the pattern, now and then with one byte spoiled.
            flaw = $urandom_range(0, 4 * span);
            for (int k = 0; k < span; k++)
              planned.push_front((k == flaw) ? needle[k] ^ byte_t'($urandom_range(1, 255))
                                             : needle[k]);
          end else if (pick < 8) begin
            planned.push_front(byte_t'(base + $urandom_range(0, letters - 1)));
          end else begin
            planned.push_front(byte_t'($urandom_range(0, 255)));
          end
        end
        // Occasional pattern load in the middle of a text.
        if ($urandom_range(0, 99) < 3)
          load_byte(INDEX_W'($urandom_range(0, SLOTS - 1)),
                    ($urandom_range(0, 1) == 1) ? byte_t'(base + $urandom_range(0, letters - 1))
                                                : byte_t'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
        send_text(planned.pop_back(), $urandom_range(0, 99) < 3);
      end
    end

    settle();
    repeat (6) @(negedge clk);
    if (errors == 0) begin
      $display("byte_pattern_match_finder verification clean");
    end else begin
      $display("byte_pattern_match_finder verification failed");
    end
    $finish;
  end

endmodule
